FILE: rtl/fcpa_pkg.sv
// Shared constants, types and helpers for the fixed chunk pool allocator.
// No dependencies; imported by every other file in rtl/ except fcpa_ram.
package fcpa_pkg;

	localparam int GRAN_W    = 16;
	localparam int CNT_W     = 11;
	localparam int REQ_W     = 16;
	localparam int ACT_W     = 2;
	localparam int STAT_W    = 3;
	localparam int REG_IDX_W = 2;

	typedef logic [GRAN_W-1:0] gran_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic [ACT_W-1:0]  action_t;

	localparam action_t ACT_REQUEST = 2'd0;
	localparam action_t ACT_RELEASE = 2'd1;
	localparam action_t ACT_QUERY   = 2'd2;

	localparam status_t STAT_OK        = 3'd0;
	localparam status_t STAT_EMPTY     = 3'd1;
	localparam status_t STAT_TOO_LARGE = 3'd2;
	localparam status_t STAT_OUTSIDE   = 3'd3;
	localparam status_t STAT_FULL      = 3'd4;

	localparam logic [REG_IDX_W-1:0] REG_BASE        = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CHUNK_BYTES = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHUNK_COUNT = 2'd2;

	localparam gran_t  RST_CHUNK_BYTES = 16'd64;
	localparam count_t RST_CHUNK_COUNT = 11'd1024;

	// zero chunk size behaves as one byte
	function automatic gran_t eff_gran(gran_t g);
		return (g == '0) ? GRAN_W'(1) : g;
	endfunction

endpackage

FILE: rtl/fixed_chunk_pool_allocator_unit.sv
// Fixed chunk pool allocator: free-index stack in RAM, serial multiply and divide.
// One item in flight: the next is accepted only once the last result has moved to the
// output register. Reset (arst_n, async): registers to defaults, stack full; a low-water
// mark stands in for clearing the stack RAM, so no clearing pass. Depends on fcpa_pkg,
// fcpa_ram, fcpa_mul, fcpa_div.
module fixed_chunk_pool_allocator_unit #(
	parameter int ADDR_WIDTH = 32,
	parameter int MAX_CHUNKS = 1024,
	localparam int S_DATA_W = ((fcpa_pkg::REQ_W + ADDR_WIDTH + 7) / 8) * 8,
	localparam int M_DATA_W = ((ADDR_WIDTH + fcpa_pkg::GRAN_W + fcpa_pkg::CNT_W + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [fcpa_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [ADDR_WIDTH-1:0]            cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [S_DATA_W-1:0]              s_axis_tdata,  // request_size, address
	input  fcpa_pkg::action_t                s_axis_tuser,  // action
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [M_DATA_W-1:0]              m_axis_tdata,  // chunk_address, size_answer, free_left
	output fcpa_pkg::status_t                m_axis_tuser   // status
);

	import fcpa_pkg::*;

	localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	function automatic count_t sat_count(count_t c);
		if (32'(c) > MAX_CHUNKS) begin
			return CNT_W'(MAX_CHUNKS);
		end
		return c;
	endfunction

	logic [ADDR_WIDTH-1:0] base_q;
	gran_t                 gran_cfg_q;
	count_t                count_cfg_q;
	count_t                ft_q;
	count_t                low_q;
	logic [2:0]            state_q;

	action_t               act_q;
	logic                  use_mem_q;
	logic [IDX_W-1:0]      pop_idx_q;
	status_t               res_status_q;
	logic [ADDR_WIDTH-1:0] res_addr_q;
	gran_t                 res_size_q;

	logic                  m_valid_q;
	status_t               m_status_q;
	logic [ADDR_WIDTH-1:0] m_addr_q;
	gran_t                 m_size_q;
	count_t                m_free_q;

	gran_t                 gran;
	count_t                count_eff;
	count_t                ft_dec;
	logic [REQ_W-1:0]      in_req;
	logic [ADDR_WIDTH-1:0] in_addr;
	logic                  accept;
	logic                  pop_go;
	logic                  div_start;
	logic                  mul_start;
	logic                  mul_done;
	logic [ADDR_WIDTH-1:0] mul_product;
	logic [IDX_W-1:0]      mul_idx;
	logic                  div_done;
	logic [ADDR_WIDTH-1:0] quotient;
	logic                  outside;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_rdata;

	assign gran      = eff_gran(gran_cfg_q);
	assign count_eff = sat_count(count_cfg_q);
	assign ft_dec    = ft_q - CNT_W'(1);
	assign in_req    = s_axis_tdata[REQ_W-1:0];
	assign in_addr   = s_axis_tdata[REQ_W +: ADDR_WIDTH];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pop_go        = accept && (s_axis_tuser == ACT_REQUEST) && (ft_q != '0)
		&& (in_req <= gran);
	assign div_start     = accept && (s_axis_tuser inside {ACT_RELEASE, ACT_QUERY});
	assign mul_start     = (state_q == S_LOAD);
	assign mul_idx       = use_mem_q ? ram_rdata : pop_idx_q;
	assign outside       = quotient >= ADDR_WIDTH'(count_eff);
	assign ram_we        = div_done && (state_q == S_DIV) && (act_q == ACT_RELEASE)
		&& !outside && (ft_q < count_eff);

	// entries below the low-water mark were never written since the last refill
	fcpa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_CHUNKS)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_W'(ft_q)),
		.wdata (quotient[IDX_W-1:0]),
		.re    (pop_go),
		.raddr (IDX_W'(ft_dec)),
		.rdata (ram_rdata)
	);

	fcpa_mul #(
		.AW (ADDR_WIDTH),
		.IW (IDX_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.base    (base_q),
		.gran    (gran),
		.idx     (mul_idx),
		.done    (mul_done),
		.product (mul_product)
	);

	fcpa_div #(
		.AW (ADDR_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_addr - base_q),
		.divisor  (gran),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			gran_cfg_q  <= RST_CHUNK_BYTES;
			count_cfg_q <= RST_CHUNK_COUNT;
			ft_q        <= sat_count(RST_CHUNK_COUNT);
			low_q       <= sat_count(RST_CHUNK_COUNT);
			state_q     <= S_IDLE;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_BASE: begin
						base_q <= cfg_data;
					end
					REG_CHUNK_BYTES: begin
						gran_cfg_q <= cfg_data[GRAN_W-1:0];
					end
					REG_CHUNK_COUNT: begin
						count_cfg_q <= cfg_data[CNT_W-1:0];
						ft_q        <= sat_count(cfg_data[CNT_W-1:0]);
						low_q       <= sat_count(cfg_data[CNT_W-1:0]);
					end
					default: begin
					end
				endcase
			end
			if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (pop_go) begin
							ft_q <= ft_dec;
							if (ft_dec < low_q) begin
								low_q <= ft_dec;
							end
							state_q <= S_LOAD;
						end else if (div_start) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_LOAD: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mul_done) begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (ram_we) begin
							ft_q <= ft_q + CNT_W'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= s_axis_tuser;
			pop_idx_q  <= IDX_W'(ft_dec);
			use_mem_q  <= (ft_dec >= low_q);
			res_addr_q <= '0;
			res_size_q <= '0;
			if (s_axis_tuser == ACT_REQUEST && ft_q == '0) begin
				res_status_q <= STAT_EMPTY;
			end else if (s_axis_tuser == ACT_REQUEST && in_req > gran) begin
				res_status_q <= STAT_TOO_LARGE;
			end else begin
				res_status_q <= STAT_OK;
			end
		end
		if (state_q == S_MUL && mul_done) begin
			res_addr_q <= mul_product;
		end
		if (state_q == S_DIV && div_done) begin
			if (outside) begin
				res_status_q <= STAT_OUTSIDE;
			end else if (act_q == ACT_QUERY) begin
				res_size_q <= gran;
			end else if (ft_q >= count_eff) begin
				res_status_q <= STAT_FULL;
			end
		end
		if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
			m_status_q <= res_status_q;
			m_addr_q   <= res_addr_q;
			m_size_q   <= res_size_q;
			m_free_q   <= ft_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = M_DATA_W'({m_free_q, m_size_q, m_addr_q});

endmodule

FILE: rtl/fcpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/fcpa_mul.sv
// Serial shift-add unit: base + gran * idx, one multiplier bit per cycle.
// Depends on fcpa_pkg.
module fcpa_mul #(
	parameter int AW = 32,
	parameter int IW = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [AW-1:0]   base,
	input  fcpa_pkg::gran_t gran,
	input  logic [IW-1:0]   idx,
	output logic            done,
	output logic [AW-1:0]   product
);

	import fcpa_pkg::*;

	localparam int CW = $clog2(IW + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [AW-1:0] acc_q;
	logic [AW-1:0] mcand_q;
	logic [IW-1:0] mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				cnt_q  <= CW'(IW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= base;
			mcand_q  <= AW'(gran);
			mplier_q <= idx;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

FILE: rtl/fcpa_div.sv
// Restoring radix-2 divider: offset / chunk size, one quotient bit per cycle.
// Depends on fcpa_pkg.
module fcpa_div #(
	parameter int AW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [AW-1:0]   dividend,
	input  fcpa_pkg::gran_t divisor,
	output logic            done,
	output logic [AW-1:0]   quotient
);

	import fcpa_pkg::*;

	localparam int CW = $clog2(AW + 1);

	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [AW-1:0]   quo_q;
	gran_t           rem_q;
	gran_t           dsr_q;
	logic [GRAN_W:0] trial;
	logic            fits;

	assign trial = {rem_q, quo_q[AW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				cnt_q  <= CW'(AW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? GRAN_W'(trial - {1'b0, dsr_q}) : trial[GRAN_W-1:0];
			quo_q <= {quo_q[AW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/fcpa_checker.sv
// Port-level checks for the allocator top level, attached by bind below.
// Depends on fcpa_pkg and fixed_chunk_pool_allocator_unit.
module fcpa_checker #(
	parameter int ADDR_WIDTH = 32,
	parameter int MAX_CHUNKS = 1024,
	localparam int M_DATA_W = ((ADDR_WIDTH + fcpa_pkg::GRAN_W + fcpa_pkg::CNT_W + 7) / 8) * 8
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [M_DATA_W-1:0] m_axis_tdata,
	input fcpa_pkg::status_t   m_axis_tuser
);

	import fcpa_pkg::*;

	logic [ADDR_WIDTH-1:0] o_addr;
	gran_t                 o_size;
	count_t                o_free;

	assign o_addr = m_axis_tdata[ADDR_WIDTH-1:0];
	assign o_size = m_axis_tdata[ADDR_WIDTH +: GRAN_W];
	assign o_free = m_axis_tdata[ADDR_WIDTH + GRAN_W +: CNT_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while busy");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STAT_OK |-> o_addr == '0 && o_size == '0)
		else $error("failed request carries address or size");

	a_size_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && o_size != '0 |-> m_axis_tuser == STAT_OK && o_addr == '0)
		else $error("size answer mixed with grant or error");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> 32'(o_free) <= MAX_CHUNKS)
		else $error("free count above pool capacity");

endmodule

bind fixed_chunk_pool_allocator_unit fcpa_checker #(
	.ADDR_WIDTH (ADDR_WIDTH),
	.MAX_CHUNKS (MAX_CHUNKS)
) u_fcpa_checker (.*);

FILE: bench/fixed_chunk_pool_allocator_unit_tb.sv
// Self-checking bench for fixed_chunk_pool_allocator_unit: a queued driver, a monitor and an
// in-bench model of the free-index stack predict every answer, across several pool settings.
// Depends on fcpa_pkg and the RTL under rtl/.
module fixed_chunk_pool_allocator_unit_tb;
	import fcpa_pkg::*;

	localparam int S_W = 48;
	localparam int M_W = 64;

	typedef struct packed {
		action_t     act;
		logic [15:0] req_size;
		logic [31:0] addr;
	} pool_req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] chunk_addr;
		gran_t       size_ans;
		count_t      free_left;
	} pool_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_W-1:0] s_tdata = '0;
	action_t s_tuser = ACT_REQUEST;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;
	status_t m_tuser;

	fixed_chunk_pool_allocator_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pool model
	logic [31:0] mdl_base;
	gran_t       mdl_gran;
	count_t      mdl_count;
	logic [9:0]  mdl_stack [1024];
	count_t      mdl_free;

	pool_req_t pending_reqs [$];
	pool_rsp_t awaited_answers [$];
	pool_req_t cur_req;
	pool_req_t next_req;
	int unsigned fails = 0;
	int unsigned gap_left = 0;
	int unsigned burst_left = 0;
	int unsigned rdy_left = 0;

	function automatic void pool_refill();
		for (int i = 0; i < 1024; i++)
			mdl_stack[i] = 10'(i);
		mdl_free = (mdl_count > 11'd1024) ? 11'd1024 : mdl_count;
	endfunction

	function automatic pool_rsp_t pool_predict(pool_req_t r);
		pool_rsp_t a;
		logic [31:0] g;
		logic [31:0] off;
		logic [31:0] idx;
		count_t cnt;
		a = '0;
		g = (mdl_gran == '0) ? 32'd1 : {16'd0, mdl_gran};
		cnt = (mdl_count > 11'd1024) ? 11'd1024 : mdl_count;
		case (r.act)
			ACT_REQUEST: begin
				if (mdl_free == '0) begin
					a.status = STAT_EMPTY;
				end else if ({16'd0, r.req_size} > g) begin
					a.status = STAT_TOO_LARGE;
				end else begin
					mdl_free = mdl_free - 11'd1;
					a.chunk_addr = mdl_base + g * {22'd0, mdl_stack[mdl_free[9:0]]};
				end
			end
			ACT_RELEASE, ACT_QUERY: begin
				off = r.addr - mdl_base;
				idx = off / g;
				if (idx >= {21'd0, cnt}) begin
					a.status = STAT_OUTSIDE;
				end else if (r.act == ACT_QUERY) begin
					a.size_ans = g[15:0];
				end else if (mdl_free >= cnt) begin
					a.status = STAT_FULL;
				end else begin
					mdl_stack[mdl_free[9:0]] = idx[9:0];
					mdl_free = mdl_free + 11'd1;
				end
			end
			default: ;
		endcase
		a.free_left = mdl_free;
		return a;
	endfunction

	function automatic void push_req(action_t act, logic [15:0] sz, logic [31:0] addr);
		pool_req_t r;
		r.act = act;
		r.req_size = sz;
		r.addr = addr;
		pending_reqs.push_back(r);
	endfunction

	function automatic pool_req_t gen_req(logic [31:0] b, int unsigned geff, int unsigned ceff);
		pool_req_t r;
		int unsigned pick;
		int unsigned idx;
		r.act = ACT_REQUEST;
		r.req_size = 16'($urandom);
		r.addr = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 42) begin
			if ($urandom_range(0, 9) < 8)
				r.req_size = 16'($urandom_range(0, geff));
			else if ($urandom_range(0, 1) == 0 && geff < 65535)
				r.req_size = 16'(geff + 1);
		end else if (pick < 93) begin
			r.act = (pick < 80) ? ACT_RELEASE : ACT_QUERY;
			if ($urandom_range(0, 99) < 85) begin
				idx = $urandom_range(0, ceff + 1);
				r.addr = b + geff * idx;
				if ($urandom_range(0, 3) == 0)
					r.addr = r.addr + $urandom_range(0, geff - 1);
			end else if ($urandom_range(0, 1) == 0) begin
				r.addr = b - 1;
			end
		end else begin
			r.act = action_t'($urandom_range(0, 3));
		end
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || awaited_answers.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	task automatic write_regs(logic [31:0] b, gran_t g, count_t c);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_BASE;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= REG_CHUNK_BYTES;
		cfg_data <= {16'd0, g};
		@(posedge clk);
		cfg_index <= REG_CHUNK_COUNT;
		cfg_data <= {21'd0, c};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mdl_base = b;
		mdl_gran = g;
		mdl_count = c;
		pool_refill();
	endtask

	task automatic run_phase(logic [31:0] b, gran_t g, count_t c, int n);
		int unsigned geff;
		int unsigned ceff;
		geff = (g == '0) ? 1 : g;
		ceff = (c > 11'd1024) ? 1024 : c;
		wait_drained();
		write_regs(b, g, c);
		for (int i = 0; i < n; i++)
			pending_reqs.push_back(gen_req(b, geff, ceff));
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
			burst_left <= 1;
		end else begin
			if (s_tvalid && s_tready)
				awaited_answers.push_back(pool_predict(cur_req));
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					s_tvalid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_reqs.size() != 0) begin
					next_req = pending_reqs.pop_front();
					cur_req <= next_req;
					s_tdata <= {next_req.addr, next_req.req_size};
					s_tuser <= next_req.act;
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rdy_left <= 0;
		end else if (rdy_left == 0) begin
			if (m_tready) begin
				m_tready <= 1'b0;
				rdy_left <= $urandom_range(0, 7);
			end else begin
				m_tready <= 1'b1;
				rdy_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
					: $urandom_range(0, 12);
			end
		end else begin
			rdy_left <= rdy_left - 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		pool_rsp_t exp_rsp;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_answers.size() == 0) begin
				$error("unexpected answer: status %0d tdata %h", m_tuser, m_tdata);
				fails++;
			end else begin
				exp_rsp = awaited_answers.pop_front();
				if (m_tuser !== exp_rsp.status) begin
					$error("status: expected %0d, got %0d", exp_rsp.status, m_tuser);
					fails++;
				end
				if (m_tdata[31:0] !== exp_rsp.chunk_addr) begin
					$error("chunk_address: expected %h, got %h", exp_rsp.chunk_addr,
						m_tdata[31:0]);
					fails++;
				end
				if (m_tdata[47:32] !== exp_rsp.size_ans) begin
					$error("size_answer: expected %0d, got %0d", exp_rsp.size_ans,
						m_tdata[47:32]);
					fails++;
				end
				if (m_tdata[58:48] !== exp_rsp.free_left) begin
					$error("free_left: expected %0d, got %0d", exp_rsp.free_left,
						m_tdata[58:48]);
					fails++;
				end
			end
		end
	end

	initial begin
		mdl_base = '0;
		mdl_gran = RST_CHUNK_BYTES;
		mdl_count = RST_CHUNK_COUNT;
		pool_refill();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: base 0, 64-byte chunks, 1024 chunks
		push_req(ACT_REQUEST, 16'd0, 32'd0);
		push_req(ACT_REQUEST, 16'd64, 32'hFFFF_FFFF);
		push_req(ACT_REQUEST, 16'd65, 32'd0);
		push_req(ACT_REQUEST, 16'hFFFF, 32'd0);
		push_req(ACT_RELEASE, 16'd0, 32'd65472);
		push_req(ACT_RELEASE, 16'hFFFF, 32'd0);
		push_req(ACT_RELEASE, 16'd0, 32'd128);      // stack already full
		push_req(ACT_RELEASE, 16'd0, 32'hFFFF_FFFF);
		push_req(ACT_RELEASE, 16'd0, 32'd65536);
		push_req(ACT_QUERY, 16'd0, 32'd0);
		push_req(ACT_QUERY, 16'd0, 32'd65535);
		push_req(ACT_QUERY, 16'd0, 32'd65536);
		push_req(action_t'(3), 16'hFFFF, 32'hFFFF_FFFF);
		wait_drained();

		// empty pool
		write_regs(32'd0, 16'd64, 11'd0);
		push_req(ACT_REQUEST, 16'd0, 32'd0);
		push_req(ACT_REQUEST, 16'hFFFF, 32'd0);
		push_req(ACT_RELEASE, 16'd0, 32'd0);
		push_req(ACT_QUERY, 16'd0, 32'd0);
		wait_drained();

		// zero chunk size, pool at the top of the address space
		write_regs(32'hFFFF_FFF0, 16'd0, 11'd2);
		push_req(ACT_REQUEST, 16'd1, 32'd0);
		push_req(ACT_REQUEST, 16'd2, 32'd0);
		push_req(ACT_REQUEST, 16'd0, 32'd0);
		push_req(ACT_REQUEST, 16'd1, 32'd0);
		push_req(ACT_REQUEST, 16'd2, 32'd0);
		push_req(ACT_RELEASE, 16'd0, 32'hFFFF_FFF1);
		push_req(ACT_RELEASE, 16'd0, 32'hFFFF_FFEF);
		push_req(ACT_QUERY, 16'd0, 32'hFFFF_FFF0);

		run_phase(32'd0, 16'd64, 11'd1024, 140);
		run_phase(32'hFFFF_FFFF, 16'd1, 11'd4, 140);
		run_phase(32'hFFFF_FF00, 16'd64, 11'd8, 140);
		run_phase($urandom, 16'hFFFF, 11'd3, 140);
		run_phase(32'd0, 16'd0, 11'h7FF, 100);
		run_phase($urandom, 16'($urandom_range(1, 16)), 11'd1, 100);
		run_phase($urandom, 16'd0, 11'd0, 40);
		repeat (6) begin
			run_phase($urandom,
				($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300)),
				11'($urandom_range(1, 16)), 140);
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (awaited_answers.size() != 0) begin
			$error("answers missing: %0d", awaited_answers.size());
			fails++;
		end
		if (fails == 0)
			$display("[fixed_chunk_pool_allocator_unit] OK");
		else
			$display("[fixed_chunk_pool_allocator_unit] ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[fixed_chunk_pool_allocator_unit] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fcpa_pkg.sv
rtl/fcpa_ram.sv
rtl/fcpa_mul.sv
rtl/fcpa_div.sv
rtl/fixed_chunk_pool_allocator_unit.sv
rtl/fcpa_checker.sv
bench/fixed_chunk_pool_allocator_unit_tb.sv
